// ===== hdl/drc_pkg.sv =====
// Shared types and constants for the dirty rectangle coalescer.
`default_nettype none

package drc_pkg;

    // Default table depth and coordinate width.
    localparam int MAX_REGIONS_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;

    // Port widths of the edge fields and of the tolerance register.
    localparam int EDGE_W = 16;
    localparam int TOL_W  = 16;

    // Tolerance is unsigned Q4.12; reset value is 1.1.
    localparam int             Q_FRAC    = 12;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd4506;

    // Input operation codes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_DIM,
        ST_ADD_AREA,
        ST_ADD_SCAN,
        ST_ADD_WRITE,
        ST_FL_READ,
        ST_FL_LOAD,
        ST_FL_EMPTY
    } drc_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_new;        // latch the incoming rectangle
        logic calc_dim;        // register width and height of the new rectangle
        logic calc_area;       // register the area of the new rectangle
        logic rd_en;           // read one table entry
        logic issue;           // the read feeds the merge test pipeline
        logic kill;            // drop everything in the merge test pipeline
        logic cap_union;       // take the union at the pipeline end for write-back
        logic cap_new;         // take the new rectangle for write-back
        logic wr_en;           // write the write-back rectangle into the table
        logic out_load_entry;  // load the output register from the read entry
        logic out_load_zero;   // load the output register with zero edges
    } drc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic res_valid;       // a merge test result is at the pipeline end
        logic res_hit;         // that entry qualifies for a merge
    } drc_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dirty_rect_coalescer_unit.sv =====
// Dirty rectangle coalescer: top level joining the controller and the datapath.
//
// Input channel: in_valid/in_stall carry one transaction per add or flush
// (opcode, rect_left/top/right/bottom). Edges are taken as signed COORD_BITS
// values from the low bits of each port; left/top inclusive, right/bottom exclusive.
// Output channel: out_valid/out_stall carry one transaction per table entry on
// a flush, last_of_run on the final one; a flush of an empty table gives one
// transaction with table_was_empty set and zero edges.
// Tolerance (unsigned Q4.12) is written through cfg_wr_en/cfg_wr_data while idle.
// An add reads the table one entry per cycle into a five-stage area and compare
// pipeline until the first matching entry is found or every entry has been tested;
// an add to an empty table skips the scan.
// A flush reads each entry through the single registered table read port and then
// loads it into the output register, waiting while the output is stalled.
// Input is stalled while an item is in progress. A result that waits in the
// output register does not block the next add; a flush waits for it to be taken.
// Reset empties the table, clears the overflow flag and sets tolerance to 1.1.
// Table contents are not cleared by reset; only entries below the count are read.
`default_nettype none

module dirty_rect_coalescer_unit
    import drc_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [TOL_W-1:0]         cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     opcode,
    input  wire logic signed [EDGE_W-1:0] rect_left,
    input  wire logic signed [EDGE_W-1:0] rect_top,
    input  wire logic signed [EDGE_W-1:0] rect_right,
    input  wire logic signed [EDGE_W-1:0] rect_bottom,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [EDGE_W-1:0]      out_left,
    output logic signed [EDGE_W-1:0]      out_top,
    output logic signed [EDGE_W-1:0]      out_right,
    output logic signed [EDGE_W-1:0]      out_bottom,
    output logic                          last_of_run,
    output logic                          table_was_empty,
    output logic                          overflowed
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    drc_cmd_t         cmd;
    drc_stat_t        stat;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] res_idx;

    // Sequencer for adds and flushes.
    drc_ctrl #(
        .MAX_REGIONS (MAX_REGIONS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .last_of_run     (last_of_run),
        .table_was_empty (table_was_empty),
        .overflowed      (overflowed),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .wr_addr         (wr_addr),
        .stat            (stat),
        .res_idx         (res_idx)
    );

    // Table, merge test pipeline and output edges.
    drc_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .COORD_BITS  (COORD_BITS),
        .IDX_W       (IDX_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_right  (rect_right),
        .rect_bottom (rect_bottom),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .stat        (stat),
        .res_idx     (res_idx),
        .out_left    (out_left),
        .out_top     (out_top),
        .out_right   (out_right),
        .out_bottom  (out_bottom)
    );

endmodule

`default_nettype wire

// ===== hdl/drc_datapath.sv =====
// Datapath: region table memory, merge test pipeline and output edge registers.
`default_nettype none

module drc_datapath
    import drc_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [TOL_W-1:0]         cfg_wr_data,
    input  wire logic signed [EDGE_W-1:0] rect_left,
    input  wire logic signed [EDGE_W-1:0] rect_top,
    input  wire logic signed [EDGE_W-1:0] rect_right,
    input  wire logic signed [EDGE_W-1:0] rect_bottom,
    input  wire drc_cmd_t                 cmd,
    input  wire logic [IDX_W-1:0]         rd_addr,
    input  wire logic [IDX_W-1:0]         wr_addr,
    output drc_stat_t                     stat,
    output logic [IDX_W-1:0]              res_idx,
    output logic signed [EDGE_W-1:0]      out_left,
    output logic signed [EDGE_W-1:0]      out_top,
    output logic signed [EDGE_W-1:0]      out_right,
    output logic signed [EDGE_W-1:0]      out_bottom
);

    localparam int CB     = COORD_BITS;
    localparam int BOX_W  = 4 * CB;
    localparam int AREA_W = 2 * CB;
    localparam int SUM_W  = AREA_W + 1;
    localparam int LHS_W  = AREA_W + Q_FRAC;
    localparam int RHS_W  = SUM_W + TOL_W;

    // Box layout: {left, top, right, bottom}, each a signed CB-bit edge.
    function automatic logic signed [CB-1:0] box_l(input logic [BOX_W-1:0] b);
        box_l = b[4*CB-1:3*CB];
    endfunction
    function automatic logic signed [CB-1:0] box_t(input logic [BOX_W-1:0] b);
        box_t = b[3*CB-1:2*CB];
    endfunction
    function automatic logic signed [CB-1:0] box_r(input logic [BOX_W-1:0] b);
        box_r = b[2*CB-1:CB];
    endfunction
    function automatic logic signed [CB-1:0] box_b(input logic [BOX_W-1:0] b);
        box_b = b[CB-1:0];
    endfunction

    // Extent between a low and a high edge; zero when not positive.
    function automatic logic [CB-1:0] extent(input logic signed [CB-1:0] lo,
                                             input logic signed [CB-1:0] hi);
        logic signed [CB:0] diff;
        diff = (CB+1)'(hi) - (CB+1)'(lo);
        extent = (hi > lo) ? diff[CB-1:0] : '0;
    endfunction

    // Bounding box of two boxes.
    function automatic logic [BOX_W-1:0] box_union(input logic [BOX_W-1:0] a,
                                                   input logic [BOX_W-1:0] b);
        logic signed [CB-1:0] l, t, r, bt;
        l  = (box_l(a) < box_l(b)) ? box_l(a) : box_l(b);
        t  = (box_t(a) < box_t(b)) ? box_t(a) : box_t(b);
        r  = (box_r(a) > box_r(b)) ? box_r(a) : box_r(b);
        bt = (box_b(a) > box_b(b)) ? box_b(a) : box_b(b);
        box_union = {l, t, r, bt};
    endfunction

    // Tolerance register.
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_wr_en)
        begin
            tol_reg <= cfg_wr_data;
        end
    end

    // New rectangle, then its width and height, then its area, each registered in turn.
    logic [BOX_W-1:0]  nb_reg;
    logic [CB-1:0]     nw_reg;
    logic [CB-1:0]     nh_reg;
    logic [AREA_W-1:0] na_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_new)
        begin
            nb_reg <= {rect_left[CB-1:0], rect_top[CB-1:0],
                       rect_right[CB-1:0], rect_bottom[CB-1:0]};
        end
        if (cmd.calc_dim)
        begin
            nw_reg <= extent(box_l(nb_reg), box_r(nb_reg));
            nh_reg <= extent(box_t(nb_reg), box_b(nb_reg));
        end
        if (cmd.calc_area)
        begin
            na_reg <= AREA_W'(nw_reg) * AREA_W'(nh_reg);
        end
    end

    // Region table: one write port and one registered read port.
    logic [BOX_W-1:0] mem [MAX_REGIONS];
    logic [BOX_W-1:0] wb_box_reg;
    logic [BOX_W-1:0] rd_box_reg;
    logic [IDX_W-1:0] s0_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wb_box_reg;
        end
        if (cmd.rd_en)
        begin
            rd_box_reg <= mem[rd_addr];
            s0_idx_reg <= rd_addr;
        end
    end

    // Merge test pipeline payload: union, extents, areas, scaled sides.
    logic [BOX_W-1:0]  s1_box_reg, s2_box_reg, s3_box_reg, s4_box_reg;
    logic [IDX_W-1:0]  s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [CB-1:0]     s1_uw_reg, s1_uh_reg, s1_ew_reg, s1_eh_reg;
    logic [AREA_W-1:0] s2_ua_reg, s2_ea_reg;
    logic [AREA_W-1:0] s3_ua_reg;
    logic [SUM_W-1:0]  s3_sum_reg;
    logic [LHS_W-1:0]  s4_lhs_reg;
    logic [RHS_W-1:0]  s4_rhs_reg;
    logic [BOX_W-1:0]  s1_union;

    assign s1_union = box_union(rd_box_reg, nb_reg);

    always_ff @(posedge clk)
    begin
        // Stage 1: bounding box and the extents of union and entry.
        s1_box_reg <= s1_union;
        s1_idx_reg <= s0_idx_reg;
        s1_uw_reg  <= extent(box_l(s1_union), box_r(s1_union));
        s1_uh_reg  <= extent(box_t(s1_union), box_b(s1_union));
        s1_ew_reg  <= extent(box_l(rd_box_reg), box_r(rd_box_reg));
        s1_eh_reg  <= extent(box_t(rd_box_reg), box_b(rd_box_reg));
        // Stage 2: areas.
        s2_box_reg <= s1_box_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_ua_reg  <= AREA_W'(s1_uw_reg) * AREA_W'(s1_uh_reg);
        s2_ea_reg  <= AREA_W'(s1_ew_reg) * AREA_W'(s1_eh_reg);
        // Stage 3: sum of the two separate areas.
        s3_box_reg <= s2_box_reg;
        s3_idx_reg <= s2_idx_reg;
        s3_ua_reg  <= s2_ua_reg;
        s3_sum_reg <= SUM_W'(s2_ea_reg) + SUM_W'(na_reg);
        // Stage 4: scale both sides of the merge test.
        s4_box_reg <= s3_box_reg;
        s4_idx_reg <= s3_idx_reg;
        s4_lhs_reg <= {s3_ua_reg, {Q_FRAC{1'b0}}};
        s4_rhs_reg <= RHS_W'(s3_sum_reg) * RHS_W'(tol_reg);
    end

    // Valid bits of the pipeline stages.
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (cmd.kill)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= cmd.rd_en && cmd.issue;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Merge decision at the pipeline end.
    assign stat.res_valid = s4_valid_reg;
    assign stat.res_hit   = (RHS_W'(s4_lhs_reg) <= s4_rhs_reg);
    assign res_idx        = s4_idx_reg;

    // Write-back rectangle: union of a qualifying entry, or the new rectangle.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_union)
        begin
            wb_box_reg <= s4_box_reg;
        end
        else if (cmd.cap_new)
        begin
            wb_box_reg <= nb_reg;
        end
    end

    // Output edge registers, sign-extended to the port width.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_entry)
        begin
            out_left   <= EDGE_W'(box_l(rd_box_reg));
            out_top    <= EDGE_W'(box_t(rd_box_reg));
            out_right  <= EDGE_W'(box_r(rd_box_reg));
            out_bottom <= EDGE_W'(box_b(rd_box_reg));
        end
        else if (cmd.out_load_zero)
        begin
            out_left   <= '0;
            out_top    <= '0;
            out_right  <= '0;
            out_bottom <= '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/drc_ctrl.sv =====
// Controller: sequences adds and flushes, owns the entry count and the output flags.
`default_nettype none

module drc_ctrl
    import drc_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             opcode,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  last_of_run,
    output logic                  table_was_empty,
    output logic                  overflowed,
    output drc_cmd_t              cmd,
    output logic [IDX_W-1:0]      rd_addr,
    output logic [IDX_W-1:0]      wr_addr,
    input  wire drc_stat_t        stat,
    input  wire logic [IDX_W-1:0] res_idx
);

    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    drc_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic [IDX_W-1:0] fl_idx_reg, fl_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             last_reg, last_next;
    logic             empty_reg, empty_next;
    logic             ovfout_reg, ovfout_next;

    logic in_accept;
    logic out_free;
    logic res_last;
    logic fl_last;
    logic table_full;

    assign in_stall        = (state_reg != ST_IDLE);
    assign in_accept       = in_valid && !in_stall;
    assign out_free        = !out_valid_reg || !out_stall;
    assign res_last        = ((CNT_W'(res_idx) + CNT_ONE) == count_reg);
    assign fl_last         = ((CNT_W'(fl_idx_reg) + CNT_ONE) == count_reg);
    assign table_full      = (count_reg == CNT_MAX);
    assign out_valid       = out_valid_reg;
    assign last_of_run     = last_reg;
    assign table_was_empty = empty_reg;
    assign overflowed      = ovfout_reg;
    assign wr_addr         = wr_idx_reg;

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            issue_idx_reg <= '0;
            fl_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            ovfout_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            issue_idx_reg <= issue_idx_next;
            fl_idx_reg    <= fl_idx_next;
            wr_idx_reg    <= wr_idx_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            empty_reg     <= empty_next;
            ovfout_reg    <= ovfout_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        issue_idx_next = issue_idx_reg;
        fl_idx_next    = fl_idx_reg;
        wr_idx_next    = wr_idx_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        ovfout_next    = ovfout_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        rd_addr        = fl_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode == OP_ADD)
                    begin
                        cmd.load_new = 1'b1;
                        state_next   = ST_ADD_DIM;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_FL_EMPTY;
                    end
                    else
                    begin
                        fl_idx_next = '0;
                        state_next  = ST_FL_READ;
                    end
                end
            end

            ST_ADD_DIM:
            begin
                cmd.calc_dim = 1'b1;
                state_next   = ST_ADD_AREA;
            end

            ST_ADD_AREA:
            begin
                // An empty table takes the rectangle without a scan.
                cmd.calc_area  = 1'b1;
                issue_idx_next = '0;
                if (count_reg == '0)
                begin
                    cmd.cap_new = 1'b1;
                    wr_idx_next = '0;
                    count_next  = CNT_ONE;
                    state_next  = ST_ADD_WRITE;
                end
                else
                begin
                    state_next = ST_ADD_SCAN;
                end
            end

            ST_ADD_SCAN:
            begin
                rd_addr = issue_idx_reg[IDX_W-1:0];
                if (stat.res_valid && stat.res_hit)
                begin
                    // First qualifying entry takes the union.
                    cmd.kill      = 1'b1;
                    cmd.cap_union = 1'b1;
                    wr_idx_next   = res_idx;
                    state_next    = ST_ADD_WRITE;
                end
                else if (stat.res_valid && res_last)
                begin
                    // No entry qualified: append, or force a merge into the last entry.
                    cmd.kill = 1'b1;
                    if (table_full)
                    begin
                        cmd.cap_union = 1'b1;
                        wr_idx_next   = res_idx;
                        ovf_next      = 1'b1;
                    end
                    else
                    begin
                        cmd.cap_new = 1'b1;
                        wr_idx_next = count_reg[IDX_W-1:0];
                        count_next  = count_reg + CNT_ONE;
                    end
                    state_next = ST_ADD_WRITE;
                end
                else if (issue_idx_reg < count_reg)
                begin
                    cmd.rd_en      = 1'b1;
                    cmd.issue      = 1'b1;
                    issue_idx_next = issue_idx_reg + CNT_ONE;
                end
            end

            ST_ADD_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_FL_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_FL_LOAD;
            end

            ST_FL_LOAD:
            begin
                if (out_free)
                begin
                    cmd.out_load_entry = 1'b1;
                    out_valid_next     = 1'b1;
                    last_next          = fl_last;
                    empty_next         = 1'b0;
                    ovfout_next        = ovf_reg;
                    if (fl_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        fl_idx_next = fl_idx_reg + IDX_W'(1);
                        state_next  = ST_FL_READ;
                    end
                end
            end

            ST_FL_EMPTY:
            begin
                if (out_free)
                begin
                    cmd.out_load_zero = 1'b1;
                    out_valid_next    = 1'b1;
                    last_next         = 1'b1;
                    empty_next        = 1'b1;
                    ovfout_next       = ovf_reg;
                    ovf_next          = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The entry count never passes the table depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count above table depth");

    // Merge test results only arrive while a scan is running.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.res_valid |-> (state_reg == ST_ADD_SCAN))
        else $error("stale merge test result outside a scan");

    // Write-back always targets an entry inside the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD_WRITE) |-> (CNT_W'(wr_idx_reg) < count_reg))
        else $error("write-back beyond the filled table");

    // The overflow flag is only raised by a forced merge into a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> table_full)
        else $error("overflow flag set with room in the table");

    // The last result of a flush empties the table and clears the flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FL_LOAD && out_free && fl_last) |=> (count_reg == '0 && !ovf_reg))
        else $error("table not cleared after flush");

endmodule

`default_nettype wire

// ===== dv/tb_dirty_rect_coalescer_unit.sv =====
// Self-checking testbench for the dirty rectangle coalescer: directed table, then random phases.
module tb_dirty_rect_coalescer_unit;
    import drc_pkg::*;

    localparam int DEPTH        = MAX_REGIONS_DEF;
    localparam int SETTLE       = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 260;
    localparam int N_PHASES     = 7;
    localparam int QUIET_PHASE  = 3;
    localparam int IDLE_PCT     = 12;

    typedef longint unsigned u64_t;
    typedef logic signed [EDGE_W-1:0] coord_t;

    typedef struct {
        coord_t l;
        coord_t t;
        coord_t r;
        coord_t b;
    } rect_t;

    typedef struct {
        rect_t box;
        logic  last;
        logic  empty;
        logic  ovf;
    } region_out_t;

    typedef struct {
        logic        op;
        rect_t       box;
        bit          typed;
        region_out_t want;
    } stim_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [TOL_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    logic             opcode;
    coord_t           rect_left;
    coord_t           rect_top;
    coord_t           rect_right;
    coord_t           rect_bottom;
    logic             out_valid;
    logic             out_stall;
    coord_t           out_left;
    coord_t           out_top;
    coord_t           out_right;
    coord_t           out_bottom;
    logic             last_of_run;
    logic             table_was_empty;
    logic             overflowed;

    // Shadow copy of the region table and its configuration.
    rect_t            region_model [DEPTH];
    int               model_count;
    logic             model_ovf;
    logic [TOL_W-1:0] model_tol;

    // Flush transactions still owed by the block, oldest first.
    region_out_t      expected_rects [$];
    int               errors = 0;
    logic             quiet  = 1'b0;

    dirty_rect_coalescer_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .rect_left       (rect_left),
        .rect_top        (rect_top),
        .rect_right      (rect_right),
        .rect_bottom     (rect_bottom),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_left        (out_left),
        .out_top         (out_top),
        .out_right       (out_right),
        .out_bottom      (out_bottom),
        .last_of_run     (last_of_run),
        .table_was_empty (table_was_empty),
        .overflowed      (overflowed)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Area with non-positive widths or heights counted as zero.
    function automatic u64_t rect_area(rect_t a);
        longint w;
        longint h;
        w = longint'(a.r) - longint'(a.l);
        h = longint'(a.b) - longint'(a.t);
        if (w < 0)
            w = 0;
        if (h < 0)
            h = 0;
        return w * h;
    endfunction

    // Plain bounding box of two rectangles, empty ones included.
    function automatic rect_t rect_union(rect_t a, rect_t b);
        rect_t u;
        u.l = (a.l < b.l) ? a.l : b.l;
        u.t = (a.t < b.t) ? a.t : b.t;
        u.r = (a.r > b.r) ? a.r : b.r;
        u.b = (a.b > b.b) ? a.b : b.b;
        return u;
    endfunction

    // Append one transaction to the queue of owed results.
    function automatic void expect_result(region_out_t res);
        expected_rects.insert(expected_rects.size(), res);
    endfunction

    // Apply one accepted transaction to the shadow table and queue what a flush emits.
    task automatic coalesce_model(logic op, rect_t nb);
        rect_t       u;
        u64_t        lhs;
        u64_t        rhs;
        bit          merged;
        region_out_t res;
        if (op == OP_ADD)
        begin
            merged = 1'b0;
            for (int i = 0; i < model_count && !merged; i++)
            begin
                u   = rect_union(region_model[i], nb);
                lhs = rect_area(u) << Q_FRAC;
                rhs = (rect_area(region_model[i]) + rect_area(nb)) * u64_t'(model_tol);
                if (lhs <= rhs)
                begin
                    region_model[i] = u;
                    merged = 1'b1;
                end
            end
            if (!merged && model_count < DEPTH)
            begin
                region_model[model_count] = nb;
                model_count++;
            end
            else if (!merged)
            begin
                // Table full: fold into the last entry and remember it.
                region_model[DEPTH-1] = rect_union(region_model[DEPTH-1], nb);
                model_ovf = 1'b1;
            end
        end
        else
        begin
            res.ovf = model_ovf;
            if (model_count == 0)
            begin
                res.box   = '{l: '0, t: '0, r: '0, b: '0};
                res.last  = 1'b1;
                res.empty = 1'b1;
                expect_result(res);
            end
            for (int i = 0; i < model_count; i++)
            begin
                res.box   = region_model[i];
                res.last  = (i == model_count - 1);
                res.empty = 1'b0;
                expect_result(res);
            end
            model_count = 0;
            model_ovf   = 1'b0;
        end
    endtask

    function automatic coord_t pick_extreme();
        case ($urandom_range(3))
            0:       return -16'sd32768;
            1:       return -16'sd1;
            2:       return 16'sd0;
            default: return 16'sd32767;
        endcase
    endfunction

    // Mostly clustered small rectangles, some raw noise, some extreme edges.
    function automatic rect_t random_rect(int cx, int cy);
        rect_t b;
        int    kind;
        int    x;
        int    y;
        kind = $urandom_range(99);
        if (kind < 75)
        begin
            x   = cx + int'($urandom_range(0, 300));
            y   = cy + int'($urandom_range(0, 300));
            b.l = 16'(x);
            b.t = 16'(y);
            b.r = 16'(x + int'($urandom_range(1, 120)));
            b.b = 16'(y + int'($urandom_range(1, 120)));
        end
        else if (kind < 90)
        begin
            b.l = 16'($urandom_range(0, 65535));
            b.t = 16'($urandom_range(0, 65535));
            b.r = 16'($urandom_range(0, 65535));
            b.b = 16'($urandom_range(0, 65535));
        end
        else
        begin
            b.l = pick_extreme();
            b.t = pick_extreme();
            b.r = pick_extreme();
            b.b = pick_extreme();
        end
        return b;
    endfunction

    function automatic stim_row_t mk_row(logic op, int l, int t, int r, int b);
        stim_row_t row;
        row.op    = op;
        row.box.l = 16'(l);
        row.box.t = 16'(t);
        row.box.r = 16'(r);
        row.box.b = 16'(b);
        row.typed = 1'b0;
        row.want  = '{box: '{l: '0, t: '0, r: '0, b: '0}, last: 1'b0, empty: 1'b0, ovf: 1'b0};
        return row;
    endfunction

    // Present one transaction after a random gap and hold it until accepted.
    task automatic send_item(logic op, rect_t box);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        rect_left   <= box.l;
        rect_top    <= box.t;
        rect_right  <= box.r;
        rect_bottom <= box.b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        coalesce_model(op, box);
    endtask

    // Drain all results, let a trailing add finish, then write the tolerance.
    task automatic write_tolerance(logic [TOL_W-1:0] tol);
        in_valid <= 1'b0;
        while (expected_rects.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= tol;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_tol = tol;
    endtask

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s expected %0d actual %0d", name, want, got);
            errors++;
        end
    endfunction

    task automatic check_result();
        region_out_t want;
        if (expected_rects.size() == 0)
        begin
            $error("unexpected result transaction: left %0d top %0d right %0d bottom %0d",
                   out_left, out_top, out_right, out_bottom);
            errors++;
        end
        else
        begin
            want = expected_rects.pop_front();
            compare_field("out_left", want.box.l, out_left);
            compare_field("out_top", want.box.t, out_top);
            compare_field("out_right", want.box.r, out_right);
            compare_field("out_bottom", want.box.b, out_bottom);
            compare_field("last_of_run", want.last, last_of_run);
            compare_field("table_was_empty", want.empty, table_was_empty);
            compare_field("overflowed", want.ovf, overflowed);
        end
    endtask

    // Result side: random stall, check every accepted transaction.
    initial
    begin : result_monitor
        forever
        begin
            out_stall <= (!quiet && $urandom_range(99) < IDLE_PCT);
            @(posedge clk);
            if (out_valid && !out_stall)
                check_result();
        end
    end

    // Ends the run when neither channel moves for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Reset, directed table, random phases, final verdict.
    initial
    begin : stimulus
        stim_row_t        rows [$];
        stim_row_t        row;
        logic [TOL_W-1:0] tol;
        int               sent;
        int               n_adds;
        int               pick;
        int               cx;
        int               cy;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        opcode      <= OP_ADD;
        rect_left   <= '0;
        rect_top    <= '0;
        rect_right  <= '0;
        rect_bottom <= '0;
        model_count = 0;
        model_ovf   = 1'b0;
        model_tol   = TOL_RESET;

        // Flush right after reset: one empty-table transaction.
        row = mk_row(OP_FLUSH, 0, 0, 0, 0);
        row.typed      = 1'b1;
        row.want.last  = 1'b1;
        row.want.empty = 1'b1;
        rows.insert(rows.size(), row);
        // Full-range rectangle comes back unchanged.
        rows.insert(rows.size(), mk_row(OP_ADD, -32768, -32768, 32767, 32767));
        row = mk_row(OP_FLUSH, 0, 0, 0, 0);
        row.typed     = 1'b1;
        row.want.box  = '{l: -16'sd32768, t: -16'sd32768, r: 16'sd32767, b: 16'sd32767};
        row.want.last = 1'b1;
        rows.insert(rows.size(), row);
        // Overlapping pair merges, a distant one is appended.
        rows.insert(rows.size(), mk_row(OP_ADD, 0, 0, 10, 10));
        rows.insert(rows.size(), mk_row(OP_ADD, 5, 0, 15, 10));
        rows.insert(rows.size(), mk_row(OP_ADD, 100, 100, 110, 110));
        rows.insert(rows.size(), mk_row(OP_FLUSH, 0, 0, 0, 0));
        // Zero-area rectangles, then enough disjoint ones to overflow the table.
        rows.insert(rows.size(), mk_row(OP_ADD, 10, 10, 5, 5));
        rows.insert(rows.size(), mk_row(OP_ADD, 20, 20, 20, 30));
        for (int i = 0; i < DEPTH; i++)
            rows.insert(rows.size(), mk_row(OP_ADD, i * 100 - 800, 1000, i * 100 - 790, 1010));
        rows.insert(rows.size(), mk_row(OP_FLUSH, 0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            send_item(rows[i].op, rows[i].box);
            if (rows[i].typed)
            begin
                void'(expected_rects.pop_back());
                expect_result(rows[i].want);
            end
        end

        // Random phases, each at its own tolerance, one of them without idling.
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0:       tol = '0;
                1:       tol = '1;
                2:       tol = 16'd4096;
                3:       tol = TOL_RESET;
                4:       tol = 16'($urandom_range(0, 65535));
                5:       tol = 16'd2048;
                default: tol = 16'd12000;
            endcase
            write_tolerance(tol);
            quiet = (ph == QUIET_PHASE);
            sent  = 0;
            while (sent < RANDOM_ITEMS / N_PHASES)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    n_adds = $urandom_range(1, 8);
                else if (pick < 85)
                    n_adds = $urandom_range(9, 15);
                else
                    n_adds = $urandom_range(16, 24);
                cx = int'($urandom_range(0, 65535)) - 32768;
                cy = int'($urandom_range(0, 65535)) - 32768;
                for (int k = 0; k < n_adds; k++)
                    send_item(OP_ADD, random_rect(cx, cy));
                send_item(OP_FLUSH, random_rect(cx, cy));
                sent += n_adds + 1;
                // Occasionally a second flush finds the table empty.
                if ($urandom_range(9) == 0)
                begin
                    send_item(OP_FLUSH, random_rect(cx, cy));
                    sent++;
                end
            end
        end
        quiet = 1'b0;

        in_valid <= 1'b0;
        while (expected_rects.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/drc_pkg.sv
hdl/drc_datapath.sv
hdl/drc_ctrl.sv
hdl/dirty_rect_coalescer_unit.sv
dv/tb_dirty_rect_coalescer_unit.sv
